/* rtl/core/wlc_pkg.sv */
package wlc_pkg;

	localparam int unsigned LEVEL_W      = 8;
	localparam int unsigned TICKS_W      = 16;
	localparam int unsigned MODE_W       = 3;
	localparam int unsigned CFG_IDX_W    = 3;
	localparam int unsigned CFG_DATA_W   = 16;
	localparam int unsigned COUNT_W_DEF  = 16;

	localparam logic [MODE_W-1:0] M_IDLE        = 3'd0;
	localparam logic [MODE_W-1:0] M_UP_DECIDE   = 3'd1;
	localparam logic [MODE_W-1:0] M_DOWN_DECIDE = 3'd2;
	localparam logic [MODE_W-1:0] M_UP_AUTO     = 3'd3;
	localparam logic [MODE_W-1:0] M_DOWN_AUTO   = 3'd4;
	localparam logic [MODE_W-1:0] M_UP_MANUAL   = 3'd5;
	localparam logic [MODE_W-1:0] M_DOWN_MANUAL = 3'd6;
	localparam logic [MODE_W-1:0] M_PINCH       = 3'd7;

	localparam logic [CFG_IDX_W-1:0] REG_POS_TOP     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POS_BOTTOM  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_PRESS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PINCH_HOLD  = 3'd4;

	localparam logic [LEVEL_W-1:0] POS_TOP_RST     = 8'd10;
	localparam logic [LEVEL_W-1:0] POS_BOTTOM_RST  = 8'd0;
	localparam logic [TICKS_W-1:0] SHORT_PRESS_RST = 16'd250;
	localparam logic [TICKS_W-1:0] STEP_RST        = 16'd200;
	localparam logic [TICKS_W-1:0] PINCH_HOLD_RST  = 16'd2500;

	typedef struct packed {
		logic [LEVEL_W-1:0] pos_top;
		logic [LEVEL_W-1:0] pos_bottom;
		logic [TICKS_W-1:0] short_press_ticks;
		logic [TICKS_W-1:0] step_ticks;
		logic [TICKS_W-1:0] pinch_hold_ticks;
	} cfg_t;

	typedef struct packed {
		logic up_raw;
		logic down_raw;
		logic up_debounced;
		logic down_debounced;
		logic pinch_detected;
	} btn_t;

endpackage

/* rtl/core/window_lifter_controller.sv */
// channel | valid     | ready     | payload
// input   | in_valid  | in_ready  | up_raw down_raw up_debounced down_debounced pinch_detected
// output  | out_valid | out_ready | window_level moving_up_led moving_down_led mode
// config  | cfg_we    | (none)    | cfg_index cfg_data
//
// one tick per cycle while in_ready is high; the result appears the cycle after the input transfer
// the state registers double as the result register, updated only on an input transfer
// in_ready is high while the result register is empty or being taken this cycle
// reset clears mode, counter and leds, sets the level to the top limit reset value
module window_lifter_controller #(
	parameter int unsigned COUNT_WIDTH = wlc_pkg::COUNT_W_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             up_raw,
	input  logic                             down_raw,
	input  logic                             up_debounced,
	input  logic                             down_debounced,
	input  logic                             pinch_detected,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [wlc_pkg::LEVEL_W-1:0]      window_level,
	output logic                             moving_up_led,
	output logic                             moving_down_led,
	output logic [wlc_pkg::MODE_W-1:0]       mode,
	input  logic                             cfg_we,
	input  logic [wlc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [wlc_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import wlc_pkg::*;

	cfg_t                   cfg;
	btn_t                   btn;
	logic                   in_xfer;
	logic                   out_valid_q;
	logic [MODE_W-1:0]      mode_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic [LEVEL_W-1:0]     level_q;
	logic                   up_led_q;
	logic                   dn_led_q;
	logic [MODE_W-1:0]      mode_nxt;
	logic [COUNT_WIDTH-1:0] cnt_nxt;
	logic [LEVEL_W-1:0]     level_nxt;
	logic                   up_led_nxt;
	logic                   dn_led_nxt;

	wlc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign btn.up_raw         = up_raw;
	assign btn.down_raw       = down_raw;
	assign btn.up_debounced   = up_debounced;
	assign btn.down_debounced = down_debounced;
	assign btn.pinch_detected = pinch_detected;

	wlc_step #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_step (
		.cfg        (cfg),
		.btn        (btn),
		.mode_cur   (mode_q),
		.cnt_cur    (cnt_q),
		.level_cur  (level_q),
		.up_led_cur (up_led_q),
		.dn_led_cur (dn_led_q),
		.mode_nxt   (mode_nxt),
		.cnt_nxt    (cnt_nxt),
		.level_nxt  (level_nxt),
		.up_led_nxt (up_led_nxt),
		.dn_led_nxt (dn_led_nxt)
	);

	assign in_ready = !out_valid_q || out_ready;
	assign in_xfer  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			mode_q      <= M_IDLE;
			cnt_q       <= '0;
			level_q     <= POS_TOP_RST;
			up_led_q    <= 1'b0;
			dn_led_q    <= 1'b0;
		end else begin
			if (in_xfer) begin
				out_valid_q <= 1'b1;
				mode_q      <= mode_nxt;
				cnt_q       <= cnt_nxt;
				level_q     <= level_nxt;
				up_led_q    <= up_led_nxt;
				dn_led_q    <= dn_led_nxt;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign window_level    = level_q;
	assign moving_up_led   = up_led_q;
	assign moving_down_led = dn_led_q;
	assign mode            = mode_q;

`ifndef ASSERT_OFF
	a_leds_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(up_led_q && dn_led_q))
		else $error("both motion leds on");

	a_leds_off_when_still: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == M_IDLE || mode_q == M_UP_DECIDE || mode_q == M_DOWN_DECIDE)
		|-> (!up_led_q && !dn_led_q))
		else $error("motion led on while not moving");

	a_xfer_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> out_valid_q)
		else $error("input transfer without result");

	a_state_holds_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_xfer |=> ($stable(mode_q) && $stable(level_q) && $stable(cnt_q)))
		else $error("state changed without input transfer");
`endif

endmodule

/* rtl/core/wlc_cfg.sv */
module wlc_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [wlc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [wlc_pkg::CFG_DATA_W-1:0]   cfg_data,
	output wlc_pkg::cfg_t                    cfg
);
	import wlc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pos_top           <= POS_TOP_RST;
			cfg_q.pos_bottom        <= POS_BOTTOM_RST;
			cfg_q.short_press_ticks <= SHORT_PRESS_RST;
			cfg_q.step_ticks        <= STEP_RST;
			cfg_q.pinch_hold_ticks  <= PINCH_HOLD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POS_TOP:     cfg_q.pos_top           <= cfg_data[LEVEL_W-1:0];
				REG_POS_BOTTOM:  cfg_q.pos_bottom        <= cfg_data[LEVEL_W-1:0];
				REG_SHORT_PRESS: cfg_q.short_press_ticks <= cfg_data[TICKS_W-1:0];
				REG_STEP:        cfg_q.step_ticks        <= cfg_data[TICKS_W-1:0];
				REG_PINCH_HOLD:  cfg_q.pinch_hold_ticks  <= cfg_data[TICKS_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/core/wlc_step.sv */
module wlc_step #(
	parameter int unsigned COUNT_WIDTH = wlc_pkg::COUNT_W_DEF
) (
	input  wlc_pkg::cfg_t                   cfg,
	input  wlc_pkg::btn_t                   btn,
	input  logic [wlc_pkg::MODE_W-1:0]      mode_cur,
	input  logic [COUNT_WIDTH-1:0]          cnt_cur,
	input  logic [wlc_pkg::LEVEL_W-1:0]     level_cur,
	input  logic                            up_led_cur,
	input  logic                            dn_led_cur,
	output logic [wlc_pkg::MODE_W-1:0]      mode_nxt,
	output logic [COUNT_WIDTH-1:0]          cnt_nxt,
	output logic [wlc_pkg::LEVEL_W-1:0]     level_nxt,
	output logic                            up_led_nxt,
	output logic                            dn_led_nxt
);
	import wlc_pkg::*;

	localparam int unsigned CMP_W = (COUNT_WIDTH > TICKS_W) ? COUNT_WIDTH : TICKS_W;

	logic [MODE_W-1:0]      m_eff;
	logic [COUNT_WIDTH-1:0] cnt_inc;
	logic [CMP_W-1:0]       cnt_cur_x;
	logic [CMP_W-1:0]       cnt_inc_x;
	logic [LEVEL_W-1:0]     lvl_up;
	logic [LEVEL_W-1:0]     lvl_dn;
	logic                   below_max;
	logic                   above_min;
	logic                   step_due;
	logic                   short_over_inc;
	logic                   short_over_cur;
	logic                   hold_over;

	always_comb begin
		cnt_inc        = (cnt_cur == '1) ? cnt_cur : cnt_cur + 1'b1;
		cnt_cur_x      = CMP_W'(cnt_cur);
		cnt_inc_x      = CMP_W'(cnt_inc);
		below_max      = level_cur < cfg.pos_top;
		above_min      = level_cur > cfg.pos_bottom;
		lvl_up         = below_max ? level_cur + 1'b1 : level_cur;
		lvl_dn         = above_min ? level_cur - 1'b1 : level_cur;
		step_due       = cnt_inc_x > CMP_W'(cfg.step_ticks);
		short_over_inc = cnt_inc_x > CMP_W'(cfg.short_press_ticks);
		short_over_cur = cnt_cur_x > CMP_W'(cfg.short_press_ticks);
		hold_over      = cnt_inc_x > CMP_W'(cfg.pinch_hold_ticks);

		m_eff = mode_cur;
		if (btn.pinch_detected && (mode_cur == M_UP_AUTO || mode_cur == M_UP_MANUAL)) begin
			m_eff = M_PINCH;
		end

		mode_nxt   = m_eff;
		cnt_nxt    = cnt_cur;
		level_nxt  = level_cur;
		up_led_nxt = up_led_cur;
		dn_led_nxt = dn_led_cur;

		case (m_eff)
			M_IDLE: begin
				if (btn.up_debounced || btn.down_debounced) begin
					mode_nxt = btn.down_debounced ? M_DOWN_DECIDE : M_UP_DECIDE;
					cnt_nxt  = '0;
				end
			end
			M_UP_DECIDE: begin
				if (!btn.up_raw) begin
					if (!short_over_cur) begin
						mode_nxt  = M_UP_AUTO;
						level_nxt = lvl_up;
					end else begin
						mode_nxt = M_IDLE;
					end
					cnt_nxt = '0;
				end else if (short_over_inc) begin
					mode_nxt  = M_UP_MANUAL;
					level_nxt = lvl_up;
					cnt_nxt   = '0;
				end else begin
					cnt_nxt = cnt_inc;
				end
			end
			M_DOWN_DECIDE: begin
				if (!btn.down_raw) begin
					if (!short_over_cur) begin
						mode_nxt  = M_DOWN_AUTO;
						level_nxt = lvl_dn;
					end else begin
						mode_nxt = M_IDLE;
					end
					cnt_nxt = '0;
				end else if (short_over_inc) begin
					mode_nxt  = M_DOWN_MANUAL;
					level_nxt = lvl_dn;
					cnt_nxt   = '0;
				end else begin
					cnt_nxt = cnt_inc;
				end
			end
			M_UP_AUTO: begin
				if (below_max) begin
					up_led_nxt = 1'b1;
					cnt_nxt    = step_due ? '0 : cnt_inc;
					level_nxt  = step_due ? lvl_up : level_cur;
				end else begin
					cnt_nxt    = '0;
					mode_nxt   = M_IDLE;
					up_led_nxt = 1'b0;
				end
				if (btn.down_debounced) begin
					cnt_nxt    = '0;
					mode_nxt   = M_IDLE;
					up_led_nxt = 1'b0;
				end
			end
			M_DOWN_AUTO: begin
				if (above_min) begin
					dn_led_nxt = 1'b1;
					cnt_nxt    = step_due ? '0 : cnt_inc;
					level_nxt  = step_due ? lvl_dn : level_cur;
				end else begin
					cnt_nxt    = '0;
					mode_nxt   = M_IDLE;
					dn_led_nxt = 1'b0;
				end
				if (btn.up_debounced) begin
					cnt_nxt    = '0;
					mode_nxt   = M_IDLE;
					dn_led_nxt = 1'b0;
				end
			end
			M_UP_MANUAL: begin
				if (below_max) begin
					up_led_nxt = 1'b1;
					cnt_nxt    = step_due ? '0 : cnt_inc;
					level_nxt  = step_due ? lvl_up : level_cur;
				end else begin
					up_led_nxt = 1'b0;
				end
				if (!btn.up_raw) begin
					mode_nxt   = M_IDLE;
					up_led_nxt = 1'b0;
				end
			end
			M_DOWN_MANUAL: begin
				if (above_min) begin
					dn_led_nxt = 1'b1;
					cnt_nxt    = step_due ? '0 : cnt_inc;
					level_nxt  = step_due ? lvl_dn : level_cur;
				end else begin
					dn_led_nxt = 1'b0;
				end
				if (!btn.down_raw) begin
					mode_nxt   = M_IDLE;
					dn_led_nxt = 1'b0;
				end
			end
			default: begin
				up_led_nxt = 1'b0;
				if (above_min) begin
					dn_led_nxt = 1'b1;
					cnt_nxt    = step_due ? '0 : cnt_inc;
					level_nxt  = step_due ? lvl_dn : level_cur;
				end else if (hold_over) begin
					cnt_nxt    = '0;
					mode_nxt   = M_IDLE;
					dn_led_nxt = 1'b0;
				end else begin
					cnt_nxt = cnt_inc;
				end
			end
		endcase
	end

endmodule

/* tb/tb.sv */
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wlc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd5;
	localparam logic [15:0] COUNT_TOP = 16'hFFFF;

	localparam btn_t NO_BTN   = 5'b00000;
	localparam btn_t UP_R     = 5'b10000;
	localparam btn_t DN_R     = 5'b01000;
	localparam btn_t UP_D     = 5'b00100;
	localparam btn_t DN_D     = 5'b00010;
	localparam btn_t PINCH_ON = 5'b00001;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               up;
		logic               dn;
		logic [MODE_W-1:0]  md;
	} tick_out_t;

	typedef enum logic {ROW_TICK, ROW_SETUP} row_kind_e;

	typedef struct {
		row_kind_e kind;
		btn_t      b;
		bit        typed;
		tick_out_t want;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic up_raw;
	logic down_raw;
	logic up_debounced;
	logic down_debounced;
	logic pinch_detected;
	logic out_valid;
	logic out_ready;
	logic [LEVEL_W-1:0] window_level;
	logic moving_up_led;
	logic moving_down_led;
	logic [MODE_W-1:0] mode;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// predicted window state and register copy
	logic [LEVEL_W-1:0] lim_hi = POS_TOP_RST;
	logic [LEVEL_W-1:0] lim_lo = POS_BOTTOM_RST;
	logic [TICKS_W-1:0] press_limit = SHORT_PRESS_RST;
	logic [TICKS_W-1:0] step_len = STEP_RST;
	logic [TICKS_W-1:0] hold_len = PINCH_HOLD_RST;
	logic [MODE_W-1:0] md = M_IDLE;
	logic [15:0] cnt = '0;
	logic [LEVEL_W-1:0] lvl = POS_TOP_RST;
	logic led_up = 1'b0;
	logic led_dn = 1'b0;

	tick_out_t pending_ticks[$];
	script_row_t button_script[$];

	int ticks_sent = 0;
	int results_checked = 0;
	int settings_used = 0;
	int mismatches = 0;
	logic [7:0] seen_modes = '0;
	bit brisk = 1'b0;
	bit hold_off_req = 1'b0;

	window_lifter_controller uut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void bump();
		if (cnt != COUNT_TOP)
			cnt = cnt + 1'b1;
	endfunction

	function automatic void nudge(input bit up);
		if (up) begin
			if (lvl < lim_hi)
				lvl = lvl + 1'b1;
		end else if (lvl > lim_lo) begin
			lvl = lvl - 1'b1;
		end
	endfunction

	function automatic void glide(input bit up);
		bump();
		if (cnt > step_len) begin
			nudge(up);
			cnt = '0;
		end
	endfunction

	function automatic void weigh_press(input bit pressed, input logic [MODE_W-1:0] auto_md,
			input logic [MODE_W-1:0] manual_md, input bit up);
		if (pressed)
			bump();
		if (!pressed) begin
			if (cnt <= press_limit) begin
				md = auto_md;
				nudge(up);
			end else begin
				md = M_IDLE;
			end
			cnt = '0;
		end else if (cnt > press_limit) begin
			md = manual_md;
			nudge(up);
			cnt = '0;
		end
	endfunction

	function automatic tick_out_t advance(input btn_t b);
		tick_out_t r;
		if (b.pinch_detected && (md == M_UP_AUTO || md == M_UP_MANUAL))
			md = M_PINCH;
		case (md)
		M_IDLE: begin
			if (b.up_debounced || b.down_debounced) begin
				md = b.down_debounced ? M_DOWN_DECIDE : M_UP_DECIDE;
				cnt = '0;
			end
		end
		M_UP_DECIDE: weigh_press(b.up_raw, M_UP_AUTO, M_UP_MANUAL, 1'b1);
		M_DOWN_DECIDE: weigh_press(b.down_raw, M_DOWN_AUTO, M_DOWN_MANUAL, 1'b0);
		M_UP_AUTO: begin
			if (lvl < lim_hi) begin
				led_up = 1'b1;
				glide(1'b1);
			end else begin
				cnt = '0;
				md = M_IDLE;
				led_up = 1'b0;
			end
			if (b.down_debounced) begin
				cnt = '0;
				md = M_IDLE;
				led_up = 1'b0;
			end
		end
		M_DOWN_AUTO: begin
			if (lvl > lim_lo) begin
				led_dn = 1'b1;
				glide(1'b0);
			end else begin
				cnt = '0;
				md = M_IDLE;
				led_dn = 1'b0;
			end
			if (b.up_debounced) begin
				cnt = '0;
				md = M_IDLE;
				led_dn = 1'b0;
			end
		end
		M_UP_MANUAL: begin
			if (lvl < lim_hi) begin
				led_up = 1'b1;
				glide(1'b1);
			end else begin
				led_up = 1'b0;
			end
			if (!b.up_raw) begin
				md = M_IDLE;
				led_up = 1'b0;
			end
		end
		M_DOWN_MANUAL: begin
			if (lvl > lim_lo) begin
				led_dn = 1'b1;
				glide(1'b0);
			end else begin
				led_dn = 1'b0;
			end
			if (!b.down_raw) begin
				md = M_IDLE;
				led_dn = 1'b0;
			end
		end
		default: begin
			// reverse to the bottom, then hold there
			led_up = 1'b0;
			if (lvl > lim_lo) begin
				led_dn = 1'b1;
				glide(1'b0);
			end else begin
				bump();
				if (cnt > hold_len) begin
					cnt = '0;
					md = M_IDLE;
					led_dn = 1'b0;
				end
			end
		end
		endcase
		r.level = lvl;
		r.up = led_up;
		r.dn = led_dn;
		r.md = md;
		return r;
	endfunction

	function automatic void check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 200)
				$display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
		end
	endfunction

	function automatic void add_row(input row_kind_e kind, input btn_t b,
			input bit typed = 1'b0, input tick_out_t want = '0);
		script_row_t row;
		row.kind = kind;
		row.b = b;
		row.typed = typed;
		row.want = want;
		button_script.push_back(row);
	endfunction

	task automatic offer_tick(input btn_t b, input bit typed, input tick_out_t want);
		int gap;
		tick_out_t predicted;
		gap = brisk ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		{up_raw, down_raw, up_debounced, down_debounced, pinch_detected} <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predicted = advance(b);
		pending_ticks.push_back(typed ? want : predicted);
		ticks_sent++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_ticks.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
		REG_POS_TOP: lim_hi = data[LEVEL_W-1:0];
		REG_POS_BOTTOM: lim_lo = data[LEVEL_W-1:0];
		REG_SHORT_PRESS: press_limit = data[TICKS_W-1:0];
		REG_STEP: step_len = data[TICKS_W-1:0];
		REG_PINCH_HOLD: hold_len = data[TICKS_W-1:0];
		default: ;
		endcase
	endtask

	task automatic program_regs(input logic [15:0] hi, input logic [15:0] lo,
			input logic [15:0] press, input logic [15:0] step, input logic [15:0] hold,
			input bit spare);
		settle();
		put_reg(REG_POS_TOP, hi);
		put_reg(REG_POS_BOTTOM, lo);
		put_reg(REG_SHORT_PRESS, press);
		put_reg(REG_STEP, step);
		put_reg(REG_PINCH_HOLD, hold);
		if (spare)
			put_reg(REG_SPARE, 16'hA5A5);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// debounced press, raw hold of random length, then coasting; the opposite button and
	// pinch come now and then throughout the hold and the coasting
	task automatic press_episode();
		bit up;
		int lim;
		int hold;
		int coast;
		btn_t b;
		up = 1'($urandom_range(0, 1));
		b = NO_BTN;
		if (up)
			b.up_debounced = 1'b1;
		else
			b.down_debounced = 1'b1;
		if ($urandom_range(0, 7) == 0)
			b = b | UP_D | DN_D;
		offer_tick(b, 1'b0, '0);
		lim = (press_limit > 30) ? 30 : int'(press_limit);
		if ($urandom_range(0, 1) == 0)
			hold = int'($urandom_range(0, lim));
		else
			hold = lim + int'($urandom_range(1, 20));
		coast = int'($urandom_range(0, 25));
		for (int i = 0; i < hold + coast; i++) begin
			b = NO_BTN;
			if (i < hold) begin
				if (up)
					b.up_raw = 1'b1;
				else
					b.down_raw = 1'b1;
			end
			if ($urandom_range(0, 15) == 0) begin
				if (up)
					b.down_debounced = 1'b1;
				else
					b.up_debounced = 1'b1;
			end
			if ($urandom_range(0, 3) == 0) begin
				if (up)
					b.down_raw = 1'($urandom_range(0, 1));
				else
					b.up_raw = 1'($urandom_range(0, 1));
			end
			b.pinch_detected = ($urandom_range(0, 11) == 0);
			offer_tick(b, 1'b0, '0);
		end
	endtask

	task automatic random_phase(input int n);
		int stop;
		logic [4:0] noise;
		stop = ticks_sent + n;
		while (ticks_sent < stop) begin
			if ($urandom_range(0, 4) == 0) begin
				noise = 5'($urandom_range(0, 31));
				offer_tick(btn_t'(noise), 1'b0, '0);
			end else begin
				press_episode();
			end
		end
	endtask

	// result side
	initial begin
		tick_out_t want;
		int stall;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = brisk ? 0 : $urandom_range(0, 9);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall = 60;
			end
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			seen_modes[mode] = 1'b1;
			if (pending_ticks.size() == 0) begin
				mismatches++;
				$display("%0t ns: result transfer with nothing expected, level %0d mode %0d",
					$time, window_level, mode);
			end else begin
				want = pending_ticks.pop_front();
				check_field("window_level", 32'(want.level), 32'(window_level));
				check_field("moving_up_led", 32'(want.up), 32'(moving_up_led));
				check_field("moving_down_led", 32'(want.dn), 32'(moving_down_led));
				check_field("mode", 32'(want.md), 32'(mode));
				results_checked++;
			end
		end
	end

	initial begin
		#(20_000_000);
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		{up_raw, down_raw, up_debounced, down_debounced, pinch_detected} <= NO_BTN;
		cfg_we <= 1'b0;
		cfg_index <= REG_POS_TOP;
		cfg_data <= '0;

		// reset registers first
		add_row(ROW_TICK, NO_BTN, 1'b1, {8'd10, 1'b0, 1'b0, M_IDLE});
		add_row(ROW_TICK, UP_D | DN_D, 1'b1, {8'd10, 1'b0, 1'b0, M_DOWN_DECIDE});
		add_row(ROW_TICK, NO_BTN);
		add_row(ROW_TICK, NO_BTN);
		add_row(ROW_TICK, UP_D);
		add_row(ROW_TICK, UP_D);
		add_row(ROW_TICK, NO_BTN);
		add_row(ROW_TICK, NO_BTN);
		add_row(ROW_TICK, UP_D);
		add_row(ROW_TICK, NO_BTN, 1'b1, {8'd10, 1'b0, 1'b0, M_UP_AUTO});
		add_row(ROW_TICK, PINCH_ON, 1'b1, {8'd10, 1'b0, 1'b1, M_PINCH});
		// tight bounds and short timing
		add_row(ROW_SETUP, NO_BTN);
		add_row(ROW_TICK, NO_BTN);
		add_row(ROW_TICK, NO_BTN);
		add_row(ROW_TICK, NO_BTN);
		add_row(ROW_TICK, UP_D);
		add_row(ROW_TICK, UP_R);
		add_row(ROW_TICK, UP_R);
		add_row(ROW_TICK, NO_BTN);
		add_row(ROW_TICK, DN_D);
		add_row(ROW_TICK, DN_D);
		add_row(ROW_TICK, DN_R);
		add_row(ROW_TICK, DN_R);
		add_row(ROW_TICK, DN_R);
		add_row(ROW_TICK, DN_R);
		add_row(ROW_TICK, NO_BTN);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (button_script[k]) begin
			if (button_script[k].kind == ROW_SETUP)
				program_regs(16'hFF0C, 16'd9, 16'd2, 16'd1, 16'd1, 1'b1);
			else
				offer_tick(button_script[k].b, button_script[k].typed, button_script[k].want);
		end

		// press held against the highest threshold
		settle();
		put_reg(REG_SHORT_PRESS, 16'd65534);
		cfg_we <= 1'b0;
		settings_used++;
		brisk = 1'b1;
		offer_tick(UP_D, 1'b0, '0);
		repeat (40) offer_tick(UP_R, 1'b0, '0);
		repeat (3) offer_tick(NO_BTN, 1'b0, '0);
		settle();
		brisk = 1'b0;

		program_regs(16'd255, 16'd0, 16'd1, 16'd1, 16'd1, 1'b0);
		hold_off_req = 1'b1;
		random_phase(150);
		program_regs(16'd1, 16'd0, 16'd3, 16'd2, 16'd4, 1'b0);
		random_phase(150);
		program_regs(16'd255, 16'd254, 16'd2, 16'd1, 16'd3, 1'b0);
		brisk = 1'b1;
		random_phase(150);
		program_regs(16'd3, 16'd200, 16'd2, 16'd1, 16'd2, 1'b0);
		brisk = 1'b0;
		random_phase(150);
		program_regs(16'd40, 16'd20, 16'd5, 16'd3, 16'd6, 1'b0);
		hold_off_req = 1'b1;
		random_phase(150);
		program_regs(16'd200, 16'd10, 16'd65534, 16'd65534, 16'd65534, 1'b0);
		random_phase(100);
		program_regs(16'($urandom_range(1, 255)), 16'($urandom_range(0, 254)),
			16'($urandom_range(1, 8)), 16'($urandom_range(1, 5)),
			16'($urandom_range(1, 12)), 1'b0);
		random_phase(175);
		program_regs(16'($urandom_range(1, 255)), 16'($urandom_range(0, 254)),
			16'($urandom_range(1, 8)), 16'($urandom_range(1, 5)),
			16'($urandom_range(1, 12)), 1'b0);
		random_phase(175);

		settle();
		repeat (4) @(posedge clk);
		$display("%0d ticks sent and %0d results checked over %0d register settings",
			ticks_sent, results_checked, settings_used);
		$display("modes reached (bit per mode, idle at bit 0): %b", seen_modes);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
